// File: sv/crc8_framed_byte_transmitter_macros.svh
// Assertion macros shared by the transmitter RTL.
`ifndef CRC8_FRAMED_BYTE_TRANSMITTER_MACROS_SVH
`define CRC8_FRAMED_BYTE_TRANSMITTER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CRC8FT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds.
`define CRC8FT_ASSERT_NEVER(label, expr, msg) \
  `CRC8FT_ASSERT(label, !(expr), msg)

`endif

// File: sv/crc8ft_pkg.sv
// Package: constants, command type and CRC-8 fold for the framed transmitter.
package crc8ft_pkg;

  // Zero filler bytes sent muted after each CRC byte.
  localparam int unsigned GapBytes = 4;
  localparam int unsigned GapCntW  = (GapBytes > 1) ? $clog2(GapBytes) : 1;

  // Depth of the command queue between front and back.
  localparam int unsigned CmdDepth = 4;
  localparam int unsigned CmdPtrW  = (CmdDepth > 1) ? $clog2(CmdDepth) : 1;
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  typedef enum logic {
    FUNC_SEND  = 1'b0,
    FUNC_ABORT = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    BK_BYTE,
    BK_CRC,
    BK_GAP
  } back_state_e;

  // One payload byte, classified by the front.
  typedef struct packed {
    logic       eop;
    logic [7:0] data;
    logic [7:0] crc;
  } cmd_t;

  // CRC-8, polynomial 0x31, one nibble per lookup.
  localparam logic [7:0] NibTable [16] = '{
    8'h00, 8'h31, 8'h62, 8'h53, 8'hc4, 8'hf5, 8'ha6, 8'h97,
    8'hb9, 8'h88, 8'hdb, 8'hea, 8'h7d, 8'h4c, 8'h1f, 8'h2e
  };

  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    v = {v[3:0], 4'h0} ^ NibTable[v[7:4]];
    v = {v[3:0], 4'h0} ^ NibTable[v[7:4]];
    return v;
  endfunction

endpackage

// File: sv/crc8ft_front.sv
// Front end: accepts input items, tracks the frame and CRC, queues commands.
module crc8ft_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              crc_init_we_i,
  input  logic [7:0]        crc_init_i,
  input  logic              push_i,
  output logic              full_o,
  input  logic              func_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_packet_i,
  output logic              cmd_push_o,
  output crc8ft_pkg::cmd_t  cmd_o,
  input  logic              cmd_full_i
);
  import crc8ft_pkg::*;

  logic [7:0] crc_init_q;
  logic [7:0] crc_q, crc_d;
  logic       in_frame_q, in_frame_d;
  logic       accept;
  logic [7:0] crc_start;
  logic [7:0] crc_next;

  assign full_o = cmd_full_i;
  assign accept = push_i && !cmd_full_i;

  // Fold the byte into the running CRC, starting a frame from the init value.
  assign crc_start = in_frame_q ? crc_q : crc_init_q;
  assign crc_next  = crc_fold(crc_start, data_byte_i);

  // Update frame state; abort drops the frame and clears the CRC.
  always_comb begin
    crc_d      = crc_q;
    in_frame_d = in_frame_q;
    if (accept) begin
      if (func_i == FUNC_ABORT) begin
        crc_d      = '0;
        in_frame_d = 1'b0;
      end else begin
        crc_d      = crc_next;
        in_frame_d = !end_of_packet_i;
      end
    end
  end

  // Queue a command for every payload transfer.
  assign cmd_push_o = accept && (func_i == FUNC_SEND);
  assign cmd_o.eop  = end_of_packet_i;
  assign cmd_o.data = data_byte_i;
  assign cmd_o.crc  = crc_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_init_q <= '0;
      crc_q      <= '0;
      in_frame_q <= 1'b0;
    end else begin
      if (crc_init_we_i) begin
        crc_init_q <= crc_init_i;
      end
      crc_q      <= crc_d;
      in_frame_q <= in_frame_d;
    end
  end

endmodule

// File: sv/crc8ft_cmd_fifo.sv
// Command queue between the front and back ends.
module crc8ft_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  crc8ft_pkg::cmd_t  data_i,
  output logic              full_o,
  input  logic              pop_i,
  output crc8ft_pkg::cmd_t  data_o,
  output logic              empty_o
);
  import crc8ft_pkg::*;

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CmdCntW-1:0] count_q;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CmdCntW'(CmdDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [CmdPtrW-1:0] ptr_inc(input logic [CmdPtrW-1:0] p);
    return (p == CmdPtrW'(CmdDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Store the entry.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: sv/crc8ft_back.sv
// Back end: expands commands into line bytes through an output register.
module crc8ft_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crc8ft_pkg::cmd_t  cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [7:0]        tx_byte_o,
  output logic              tx_mute_o,
  output logic              last_o
);
  import crc8ft_pkg::*;

  back_state_e        state_q, state_d;
  logic [GapCntW-1:0] gap_cnt_q, gap_cnt_d;
  logic [7:0]         crc_q;
  logic               res_valid_q;
  logic [7:0]         res_byte_q, res_byte_d;
  logic               res_mute_q, res_mute_d;
  logic               res_last_q, res_last_d;
  logic               advance;
  logic               load;
  logic               gap_last;

  assign advance  = !res_valid_q || pop_i;
  assign gap_last = (gap_cnt_q == GapCntW'(GapBytes - 1));

  // Output decode: pick the next line byte for the current step.
  always_comb begin
    cmd_pop_o  = 1'b0;
    load       = 1'b0;
    res_byte_d = '0;
    res_mute_d = 1'b0;
    res_last_d = 1'b0;
    unique case (state_q)
      BK_BYTE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o  = advance;
          load       = 1'b1;
          res_byte_d = cmd_i.data;
          res_last_d = !cmd_i.eop;
        end
      end
      BK_CRC: begin
        load       = 1'b1;
        res_byte_d = crc_q;
      end
      BK_GAP: begin
        load       = 1'b1;
        res_mute_d = 1'b1;
        res_last_d = gap_last;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  // Next state: byte, then CRC and filler run on an end mark.
  always_comb begin
    state_d   = state_q;
    gap_cnt_d = gap_cnt_q;
    unique case (state_q)
      BK_BYTE: begin
        if (cmd_pop_o && cmd_i.eop) begin
          state_d = BK_CRC;
        end
      end
      BK_CRC: begin
        if (advance) begin
          state_d   = BK_GAP;
          gap_cnt_d = '0;
        end
      end
      BK_GAP: begin
        if (advance) begin
          if (gap_last) begin
            state_d = BK_BYTE;
          end else begin
            gap_cnt_d = gap_cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = BK_BYTE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_BYTE;
      gap_cnt_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      gap_cnt_q <= gap_cnt_d;
      if (advance) begin
        res_valid_q <= load;
      end
    end
  end

  // Hold the frame CRC and the waiting result.
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      crc_q <= cmd_i.crc;
    end
    if (advance && load) begin
      res_byte_q <= res_byte_d;
      res_mute_q <= res_mute_d;
      res_last_q <= res_last_d;
    end
  end

  assign empty_o   = !res_valid_q;
  assign tx_byte_o = res_byte_q;
  assign tx_mute_o = res_mute_q;
  assign last_o    = res_last_q;

endmodule

// File: sv/crc8_framed_byte_transmitter.sv
// CRC-8 framed byte transmitter: top level.
//
// Input queue side: present func_i, data_byte_i and end_of_packet_i with
// push; the item transfers on a clock edge with push high and full low.
// func_i 0 sends a payload byte, 1 aborts the open frame (no output).
// Output queue side: while empty is low the oldest result sits on tx_byte_o,
// tx_mute_o and last_o; it transfers on an edge with pop high.
// A payload byte is passed through; a byte with end_of_packet_i is followed by
// the CRC-8 (poly 0x31, started from crc_init at the frame's first byte) and
// GapBytes zero bytes with tx_mute_o high, the final one with last_o high.
// crc_init is written through crc_init_we_i / crc_init_i while no item is in flight.
// An input item is first written into the command queue, then loaded into the back end's output register.
// The back end's output register emits one byte per cycle while pop stays high,
// and an end-marked item drains as 2 + GapBytes line bytes.
// A four-entry command queue lets input keep flowing while results stall.
// When pop stays low the output register holds, the queue fills and full
// rises. Reset empties the queue, closes the frame and clears crc_init.
`include "crc8_framed_byte_transmitter_macros.svh"

module crc8_framed_byte_transmitter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       crc_init_we_i,
  input  logic [7:0] crc_init_i,
  input  logic       push,
  output logic       full,
  input  logic       func_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_packet_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] tx_byte_o,
  output logic       tx_mute_o,
  output logic       last_o
);
  import crc8ft_pkg::*;

  cmd_t cmd_in, cmd_out;
  logic cmd_push, cmd_full, cmd_pop, cmd_empty;

  crc8ft_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .crc_init_we_i   (crc_init_we_i),
    .crc_init_i      (crc_init_i),
    .push_i          (push),
    .full_o          (full),
    .func_i          (func_i),
    .data_byte_i     (data_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in),
    .cmd_full_i      (cmd_full)
  );

  crc8ft_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  crc8ft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .tx_byte_o   (tx_byte_o),
    .tx_mute_o   (tx_mute_o),
    .last_o      (last_o)
  );

  // Queue handshakes between front and back.
  `CRC8FT_ASSERT_NEVER(a_no_push_full, cmd_push && cmd_full, "command pushed into full queue")
  `CRC8FT_ASSERT_NEVER(a_no_pop_empty, cmd_pop && cmd_empty, "command popped from empty queue")

  // Filler bytes are zero, and a filler run is not broken by idle cycles.
  `CRC8FT_ASSERT_NEVER(a_mute_zero, !empty && tx_mute_o && (tx_byte_o != 8'h00), "muted byte not zero")
  `CRC8FT_ASSERT(a_gap_run, (!empty && pop && tx_mute_o && !last_o) |=> (!empty && tx_mute_o), "filler run broken")

endmodule

// File: tb/crc8_framed_byte_transmitter_checker.sv
// Checker: predicts the transmitter's line bytes from observed transfers and compares them.
module crc8_framed_byte_transmitter_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       crc_init_we_i,
  input  logic [7:0] crc_init_i,
  input  logic       push_i,
  input  logic       full_i,
  input  logic       func_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_packet_i,
  input  logic       empty_i,
  input  logic       pop_i,
  input  logic [7:0] tx_byte_i,
  input  logic       tx_mute_i,
  input  logic       last_i,
  output int         pending_o,
  output int         fail_count_o
);
  import crc8ft_pkg::*;

  localparam logic [7:0] CrcPoly = 8'h31;

  typedef struct packed {
    logic [7:0] data;
    logic       mute;
    logic       last;
  } line_byte_t;

  line_byte_t tx_expect_q[$];
  logic [7:0] crc_init_q = 8'h00;
  logic [7:0] frame_crc  = 8'h00;
  logic       frame_open = 1'b0;

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  // Fold one byte into the CRC, MSB first, one bit per step.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  task automatic report_error(input string msg);
    $display("[%0t] line byte error: %s", $realtime, msg);
    fail_count_o++;
  endtask

  // Advance the frame state and queue the bytes one input transfer puts on the line.
  task automatic predict_line_bytes(input logic func, input logic [7:0] data, input logic eop);
    if (func == FUNC_ABORT) begin
      frame_open = 1'b0;
      frame_crc  = 8'h00;
      return;
    end
    if (!frame_open) begin
      frame_crc  = crc_init_q;
      frame_open = 1'b1;
    end
    frame_crc = crc8_update(frame_crc, data);
    if (!eop) begin
      tx_expect_q.push_back('{data: data, mute: 1'b0, last: 1'b1});
    end else begin
      tx_expect_q.push_back('{data: data, mute: 1'b0, last: 1'b0});
      tx_expect_q.push_back('{data: frame_crc, mute: 1'b0, last: 1'b0});
      for (int g = 0; g < GapBytes; g++) begin
        tx_expect_q.push_back('{data: 8'h00, mute: 1'b1, last: (g == GapBytes - 1)});
      end
      frame_open = 1'b0;
    end
  endtask

  // Compare one popped line byte with the oldest expectation.
  task automatic check_line_byte();
    line_byte_t exp_b;
    if (tx_expect_q.size() == 0) begin
      report_error($sformatf("unexpected byte %02h mute %0b last %0b",
                             tx_byte_i, tx_mute_i, last_i));
      return;
    end
    exp_b = tx_expect_q.pop_front();
    if (tx_byte_i !== exp_b.data)
      report_error($sformatf("tx_byte %02h, expected %02h", tx_byte_i, exp_b.data));
    if (tx_mute_i !== exp_b.mute)
      report_error($sformatf("tx_mute %0b, expected %0b", tx_mute_i, exp_b.mute));
    if (last_i !== exp_b.last)
      report_error($sformatf("last %0b, expected %0b", last_i, exp_b.last));
  endtask

  // Track config, predict on input transfers, check on output transfers.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      crc_init_q = 8'h00;
      frame_crc  = 8'h00;
      frame_open = 1'b0;
      tx_expect_q.delete();
    end else begin
      if (crc_init_we_i) crc_init_q = crc_init_i;
      if (push_i && !full_i) predict_line_bytes(func_i, data_byte_i, end_of_packet_i);
      if (pop_i && !empty_i) check_line_byte();
    end
    pending_o = tx_expect_q.size();
  end

endmodule

// File: tb/crc8_framed_byte_transmitter_tb.sv
// Testbench top: clock, reset, byte stimulus, line receiver and verdict.
module crc8_framed_byte_transmitter_tb;
  import crc8ft_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 16;
  localparam int HoldCycles    = 300;
  localparam int PhaseItems    = 100;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       crc_init_we_i   = 1'b0;
  logic [7:0] crc_init_i      = 8'h00;
  logic       push            = 1'b0;
  logic       func_i          = 1'b0;
  logic [7:0] data_byte_i     = 8'h00;
  logic       end_of_packet_i = 1'b0;
  logic       pop             = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] tx_byte_o;
  logic       tx_mute_o;
  logic       last_o;

  int pending;
  int fail_count;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int items_sent   = 0;
  int quiet_cycles = 0;
  bit rx_hold_req  = 1'b0;

  always #4 clk_i = ~clk_i;

  crc8_framed_byte_transmitter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .crc_init_we_i   (crc_init_we_i),
    .crc_init_i      (crc_init_i),
    .push            (push),
    .full            (full),
    .func_i          (func_i),
    .data_byte_i     (data_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .empty           (empty),
    .pop             (pop),
    .tx_byte_o       (tx_byte_o),
    .tx_mute_o       (tx_mute_o),
    .last_o          (last_o)
  );

  crc8_framed_byte_transmitter_checker line_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .crc_init_we_i   (crc_init_we_i),
    .crc_init_i      (crc_init_i),
    .push_i          (push),
    .full_i          (full),
    .func_i          (func_i),
    .data_byte_i     (data_byte_i),
    .end_of_packet_i (end_of_packet_i),
    .empty_i         (empty),
    .pop_i           (pop),
    .tx_byte_i       (tx_byte_o),
    .tx_mute_i       (tx_mute_o),
    .last_i          (last_o),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  // End the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("crc8_framed_byte_transmitter verification failed");
        $finish;
      end
    end
  end

  // Line receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Offer one item after a random idle gap and hold it until it transfers.
  task automatic send_item(input func_e f, input logic [7:0] data, input logic eop);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push            <= 1'b1;
    func_i          <= f;
    data_byte_i     <= data;
    end_of_packet_i <= eop;
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  // Drop push and wait until every expected byte has come out.
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_crc_init(input logic [7:0] value);
    settle();
    crc_init_we_i <= 1'b1;
    crc_init_i    <= value;
    @(posedge clk_i);
    crc_init_we_i <= 1'b0;
  endtask

  // Send one packet of random bytes, sometimes cut short by an abort.
  task automatic send_packet(input int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 6) begin
        send_item(FUNC_ABORT, 8'($urandom_range(255)), 1'($urandom_range(1)));
        return;
      end
      send_item(FUNC_SEND, 8'($urandom_range(255)), (i == len - 1));
    end
  endtask

  // Mostly well-formed packets, with stray aborts and unframed noise mixed in.
  task automatic run_traffic(input int n_items);
    int target;
    int pick;
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        send_packet(($urandom_range(19) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6));
      end else if (pick < 88) begin
        send_item(FUNC_ABORT, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        send_item($urandom_range(1) ? FUNC_ABORT : FUNC_SEND, 8'($urandom_range(255)),
                  1'($urandom_range(1)));
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] init_val;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single-byte frame from the reset init, multi-byte frame, aborts.
    send_item(FUNC_SEND, 8'h00, 1'b1);
    send_item(FUNC_SEND, 8'hff, 1'b0);
    send_item(FUNC_SEND, 8'h00, 1'b0);
    send_item(FUNC_SEND, 8'ha5, 1'b1);
    send_item(FUNC_ABORT, 8'hff, 1'b1);
    send_item(FUNC_SEND, 8'h12, 1'b0);
    send_item(FUNC_ABORT, 8'h00, 1'b0);
    send_item(FUNC_SEND, 8'h34, 1'b1);
    // Init changes while a frame is open: that frame keeps its old start.
    send_item(FUNC_SEND, 8'h5a, 1'b0);
    write_crc_init(8'hff);
    send_item(FUNC_SEND, 8'hc3, 1'b1);
    send_item(FUNC_SEND, 8'h80, 1'b1);
    send_item(FUNC_SEND, 8'h7f, 1'b0);
    send_item(FUNC_ABORT, 8'h55, 1'b0);
    send_item(FUNC_SEND, 8'h01, 1'b1);

    // Random phases with different idle mixes and init values.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          tx_idle_pct = 0;  rx_stall_pct = 0;  init_val = 8'h80;
        end
        1: begin
          tx_idle_pct = 78; rx_stall_pct = 0;  init_val = 8'hff;
        end
        2: begin
          tx_idle_pct = 0;  rx_stall_pct = 78; init_val = 8'h00;
        end
        default: begin
          tx_idle_pct = 15; rx_stall_pct = 15; init_val = 8'($urandom_range(255));
        end
      endcase
      write_crc_init(init_val);
      // Hold the receiver off while the sender floods, to fill the block.
      if (p == 0) rx_hold_req = 1'b1;
      run_traffic(PhaseItems);
    end

    settle();
    if (fail_count == 0) begin
      $display("crc8_framed_byte_transmitter verification clean");
    end else begin
      $display("crc8_framed_byte_transmitter verification failed");
    end
    $finish;
  end

endmodule
